// ===== design/tfn_pkg.sv =====
// Package for triangle_face_normal: types and constants.
// No dependencies.
`default_nettype none
package tfn_pkg;
  localparam int unsigned NORM_ONE = 16384;
  localparam int unsigned RED_BITS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CROSS,
    ST_SCALE,
    ST_EMIT
  } tfn_state_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_M1,
    SC_W1,
    SC_M2,
    SC_W2,
    SC_CMP
  } tfn_scale_state_t;
endpackage
`default_nettype wire

// ===== design/triangle_face_normal.sv =====
// Top level of the triangle face normal unit.
// Uses tfn_pkg, tfn_mul, tfn_scale.
//
// channel | dir | ports
// in      | in  | in_valid, in_ready, in_component_value
// out     | out | out_valid, out_ready, out_normal_x/y/z, out_degenerate, out_last
// cfg     | in  | cfg_valid, cfg_ready, cfg_data
//
// Components are accepted only while idle. After a triangle's last component the
// input stalls while the cross product (six 33x33 serial products) and three
// serial binary-search scalings (up to 15 steps of two serial products each) run
// on the shift-add multipliers, one in this unit and one in tfn_scale.
// Three items then leave; the next triangle is taken after the third is taken.
// Reset is synchronous, active low; coordinates are not reset.
`default_nettype none
module triangle_face_normal #(
  parameter int unsigned MAX_COMPONENTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [31:0] in_component_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic             out_degenerate,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);
  import tfn_pkg::*;
  localparam int unsigned CIW = $clog2(MAX_COMPONENTS);

  tfn_state_t st_r, st_nxt;
  logic [3:0]     cpv_r;
  logic [CIW-1:0] ci_r;
  logic [1:0]     vi_r;
  logic signed [31:0] crd_r [9];
  logic [4:0]     cnt;
  logic           in_acc, vend;

  logic [3:0]  step_r, step_nxt;
  logic [1:0]  ecnt_r, ecnt_nxt;
  logic [65:0] nmag_r [3];
  logic [2:0]  nneg_r;
  logic [65:0] ptmp_r;
  logic        ptneg_r;
  logic [15:0] red_r [3];
  logic [33:0] s_r;
  logic [15:0] fld_r [3];
  logic        degen_r;

  logic        mstart, mdone;
  logic [32:0] ma, mb;
  logic [65:0] mp;
  logic        sstart, sdone;
  logic [14:0] sq;

  logic signed [32:0] e1 [3], e2 [3];
  logic [6:0] blen;
  logic [6:0] kshift;

  assign cnt = (cpv_r < 4'd3) ? 5'd3 :
               (5'(cpv_r) > 5'(MAX_COMPONENTS)) ? 5'(MAX_COMPONENTS) : 5'(cpv_r);
  assign in_ready = (st_r == ST_IDLE);
  assign in_acc = in_valid && in_ready;
  assign vend = (5'(ci_r) + 5'd1) >= cnt;
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = 33'(crd_r[3+i]) - 33'(crd_r[i]);
      e2[i] = 33'(crd_r[6+i]) - 33'(crd_r[i]);
    end
  end

  // products of cross term ecnt_r; steps 0-1 first, 2-3 second
  logic signed [32:0] pa, pb;
  always_comb begin
    pa = '0;
    pb = '0;
    case (ecnt_r)
      2'd0: begin pa = step_r[1] ? e1[2] : e1[1]; pb = step_r[1] ? e2[1] : e2[2]; end
      2'd1: begin pa = step_r[1] ? e1[0] : e1[2]; pb = step_r[1] ? e2[2] : e2[0]; end
      default: begin pa = step_r[1] ? e1[1] : e1[0]; pb = step_r[1] ? e2[0] : e2[1]; end
    endcase
  end

  tfn_mul #(.W(33)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
    .done(mdone), .p(mp)
  );

  tfn_scale u_scale (
    .clk(clk), .rst_n(rst_n), .start(sstart), .c(red_r[ecnt_r]), .s(s_r),
    .done(sdone), .q(sq)
  );

  always_comb begin
    blen = '0;
    for (int i = 0; i < 66; i++) begin
      if (nmag_r[0][i] || nmag_r[1][i] || nmag_r[2][i]) blen = 7'(i + 1);
    end
  end
  assign kshift = (blen > 7'(RED_BITS)) ? blen - 7'(RED_BITS) : 7'd0;

  // step_r in CROSS: 0 start p, 1 wait p, 2 start r, 3 wait r and combine, 4 next term
  // in SCALE: 0 reduce, 1..3 squares, 4 start, 5 wait, 6 degenerate skip
  always_comb begin
    st_nxt = st_r;
    step_nxt = step_r;
    ecnt_nxt = ecnt_r;
    case (st_r)
      ST_IDLE: if (in_acc && vend && vi_r == 2'd2) begin
        st_nxt = ST_CROSS;
        step_nxt = '0;
        ecnt_nxt = '0;
      end
      ST_CROSS: begin
        case (step_r)
          4'd0, 4'd2: step_nxt = step_r + 4'd1;
          4'd1, 4'd3: if (mdone) step_nxt = step_r + 4'd1;
          default: begin
            step_nxt = '0;
            if (ecnt_r == 2'd2) begin
              ecnt_nxt = '0;
              st_nxt = ST_SCALE;
            end else ecnt_nxt = ecnt_r + 2'd1;
          end
        endcase
      end
      ST_SCALE: begin
        case (step_r)
          4'd0: step_nxt = (blen == 7'd0) ? 4'd6 : 4'd1;
          4'd1, 4'd2, 4'd3: step_nxt = step_r + 4'd1;
          4'd4: step_nxt = 4'd5;
          4'd5: if (sdone) begin
            if (ecnt_r == 2'd2) begin
              st_nxt = ST_EMIT;
              ecnt_nxt = '0;
            end else begin
              ecnt_nxt = ecnt_r + 2'd1;
              step_nxt = 4'd4;
            end
          end
          default: begin
            st_nxt = ST_EMIT;
            ecnt_nxt = '0;
          end
        endcase
      end
      ST_EMIT: if (out_ready) begin
        if (ecnt_r == 2'd2) st_nxt = ST_IDLE;
        ecnt_nxt = ecnt_r + 2'd1;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // cross product terms go through the serial multiplier; the sum of
  // squares uses narrow 16x16 products
  always_comb begin
    mstart = 1'b0;
    ma = '0;
    mb = '0;
    sstart = 1'b0;
    if (st_r == ST_CROSS && (step_r == 4'd0 || step_r == 4'd2)) begin
      mstart = 1'b1;
      ma = pa[32] ? 33'(-pa) : 33'(pa);
      mb = pb[32] ? 33'(-pb) : 33'(pb);
    end
    if (st_r == ST_SCALE && step_r == 4'd4) sstart = 1'b1;
  end

  always_comb begin
    out_valid = (st_r == ST_EMIT);
    out_normal_x = fld_r[0];
    out_normal_y = fld_r[1];
    out_normal_z = fld_r[2];
    out_degenerate = degen_r;
    out_last = (ecnt_r == 2'd2);
  end

  logic pneg_c;
  assign pneg_c = pa[32] ^ pb[32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cpv_r <= 4'd3;
      ci_r <= '0;
      vi_r <= '0;
      step_r <= '0;
      ecnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      step_r <= step_nxt;
      ecnt_r <= ecnt_nxt;
      if (cfg_valid && cfg_ready) cpv_r <= cfg_data;
      if (in_acc) begin
        if (vend) begin
          ci_r <= '0;
          vi_r <= (vi_r == 2'd2) ? 2'd0 : vi_r + 2'd1;
        end else ci_r <= ci_r + 1'b1;
      end
    end
    if (in_acc && ci_r < CIW'(3) && vi_r < 2'd3)
      crd_r[4'(vi_r) * 4'd3 + 4'(ci_r)] <= in_component_value;
    if (st_r == ST_CROSS) begin
      if (step_r == 4'd1 && mdone) begin
        ptmp_r <= mp;
        ptneg_r <= pneg_c;
      end
      if (step_r == 4'd3 && mdone) begin
        if (ptneg_r != pneg_c) begin
          nmag_r[ecnt_r] <= ptmp_r + mp;
          nneg_r[ecnt_r] <= ptneg_r;
        end else if (ptmp_r >= mp) begin
          nmag_r[ecnt_r] <= ptmp_r - mp;
          nneg_r[ecnt_r] <= ptneg_r;
        end else begin
          nmag_r[ecnt_r] <= mp - ptmp_r;
          nneg_r[ecnt_r] <= !ptneg_r;
        end
      end
    end
    if (st_r == ST_SCALE) begin
      case (step_r)
        4'd0: begin
          degen_r <= (blen == 7'd0);
          s_r <= '0;
          for (int i = 0; i < 3; i++) begin
            red_r[i] <= 16'(nmag_r[i] >> kshift);
            fld_r[i] <= '0;
          end
        end
        4'd1, 4'd2, 4'd3:
          s_r <= s_r + 34'(32'(red_r[step_r[1:0] - 2'd1]) *
                           32'(red_r[step_r[1:0] - 2'd1]));
        4'd5: if (sdone)
          fld_r[ecnt_r] <= nneg_r[ecnt_r] ? -16'(sq) : 16'(sq);
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/tfn_mul.sv =====
// Serial shift-add multiplier: one multiplier bit per cycle.
// Uses tfn_pkg.
`default_nettype none
module tfn_mul #(
  parameter int unsigned W = 33
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [W-1:0]     a,
  input  wire logic [W-1:0]     b,
  output logic                  done,
  output logic [2*W-1:0]        p
);
  import tfn_pkg::*;
  localparam int unsigned CW = $clog2(W + 1);
  logic [2*W-1:0] acc_r, acc_nxt;
  logic [2*W-1:0] mc_r, mc_nxt;
  logic [W-1:0]   mp_r, mp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;

  always_comb begin
    acc_nxt = acc_r;
    mc_nxt = mc_r;
    mp_nxt = mp_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt = '0;
      mc_nxt = {{W{1'b0}}, a};
      mp_nxt = b;
      cnt_nxt = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt = mc_r << 1;
      mp_nxt = mp_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r <= mc_nxt;
    mp_r <= mp_nxt;
  end

  assign done = busy_r && (cnt_r == CW'(1)) ? 1'b0 : !busy_r;
  assign p = acc_r;
endmodule
`default_nettype wire

// ===== design/tfn_scale.sv =====
// Bit-serial unit scaler: q = round(16384*c/sqrt(s)) by binary search,
// the compare product formed serially in tfn_mul. Uses tfn_pkg, tfn_mul.
`default_nettype none
module tfn_scale (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] c,
  input  wire logic [33:0] s,
  output logic             done,
  output logic [14:0]      q
);
  import tfn_pkg::*;
  tfn_scale_state_t st_r, st_nxt;
  logic [14:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [63:0] tgt_r, tgt_nxt;
  logic [31:0] tsq_r, tsq_nxt;
  logic [14:0] mid;
  logic [15:0] t;
  logic        mstart;
  logic [33:0] ma, mb;
  logic        mdone;
  logic [67:0] mp;
  logic        done_r, done_nxt;

  assign mid = 15'((16'(lo_r) + 16'(hi_r) + 16'd1) >> 1);
  assign t = {mid, 1'b0} - 16'd1;

  tfn_mul #(.W(34)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
    .done(mdone), .p(mp)
  );

  always_comb begin
    st_nxt = st_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    tgt_nxt = tgt_r;
    tsq_nxt = tsq_r;
    done_nxt = 1'b0;
    case (st_r)
      SC_IDLE: if (start) begin
        lo_nxt = '0;
        hi_nxt = 15'(NORM_ONE);
        tgt_nxt = {2'b0, 32'(c) * 32'(c), 30'b0};
        st_nxt = SC_CMP;
      end
      SC_CMP: begin
        if (lo_r >= hi_r) begin
          done_nxt = 1'b1;
          st_nxt = SC_IDLE;
        end else st_nxt = SC_M1;
      end
      SC_M1: st_nxt = SC_W1;
      SC_W1: if (mdone) begin
        tsq_nxt = mp[31:0];
        st_nxt = SC_M2;
      end
      SC_M2: st_nxt = SC_W2;
      SC_W2: if (mdone) begin
        if (mp <= {4'b0, tgt_r}) lo_nxt = mid;
        else hi_nxt = mid - 15'd1;
        st_nxt = SC_CMP;
      end
      default: st_nxt = SC_IDLE;
    endcase
  end

  always_comb begin
    mstart = 1'b0;
    ma = '0;
    mb = '0;
    case (st_r)
      SC_M1: begin
        mstart = 1'b1;
        ma = 34'(t);
        mb = 34'(t);
      end
      SC_M2: begin
        mstart = 1'b1;
        ma = 34'(tsq_r);
        mb = s;
      end
      default: mstart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SC_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= done_nxt;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    tgt_r <= tgt_nxt;
    tsq_r <= tsq_nxt;
  end

  assign done = done_r;
  assign q = lo_r;
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for triangle_face_normal: streams vertex components, predicts each
// triangle's unit normal in a scoreboard class and checks every result item.
// Depends on tfn_pkg and the triangle_face_normal RTL.
`default_nettype none
module testbench;
  import tfn_pkg::*;

  localparam int unsigned MAX_COMP = 8;
  localparam int unsigned CFG_COMPONENTS = 0;
  localparam int LIMIT_CYCLES = 3000000;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic degen;
    logic last;
  } normal_t;

  class normal_board;
    normal_t expected_normals[$];
    int unsigned comps_per_vertex = 3;
    int unsigned comp_idx = 0;
    int unsigned vert_idx = 0;
    logic signed [31:0] coords[9];
    int errors = 0;

    function automatic logic [15:0] unit_scale(logic [127:0] c, logic [127:0] s);
      logic [127:0] lo, hi, mid, t, target;
      lo = 0;
      hi = NORM_ONE;
      target = (c * c) << 30;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        t = 2 * mid - 1;
        if (t * t * s <= target) lo = mid;
        else hi = mid - 1;
      end
      return lo[15:0];
    endfunction

    function void compute_normal();
      logic signed [127:0] e1[3], e2[3], crs[3];
      logic [127:0] mag[3], red[3], s;
      logic [15:0] q;
      int unsigned maxlen, k;
      normal_t r;
      for (int i = 0; i < 3; i++) begin
        e1[i] = 128'(coords[3 + i]) - 128'(coords[i]);
        e2[i] = 128'(coords[6 + i]) - 128'(coords[i]);
      end
      crs[0] = e1[1] * e2[2] - e1[2] * e2[1];
      crs[1] = e1[2] * e2[0] - e1[0] * e2[2];
      crs[2] = e1[0] * e2[1] - e1[1] * e2[0];
      maxlen = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = crs[i] < 0 ? -crs[i] : crs[i];
        for (int b = 0; b < 128; b++)
          if (mag[i][b] && b + 1 > maxlen) maxlen = b + 1;
      end
      k = maxlen > RED_BITS ? maxlen - RED_BITS : 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        red[i] = mag[i] >> k;
        s += red[i] * red[i];
      end
      r.degen = (maxlen == 0);
      for (int i = 0; i < 3; i++) begin
        q = r.degen ? 16'd0 : unit_scale(red[i], s);
        if (crs[i] < 0) q = -q;
        if (i == 0) r.nx = q;
        else if (i == 1) r.ny = q;
        else r.nz = q;
      end
      for (int i = 0; i < 3; i++) begin
        r.last = (i == 2);
        expected_normals = {expected_normals, r};
      end
    endfunction

    function void note_component(logic signed [31:0] v);
      int unsigned cnt;
      cnt = comps_per_vertex < 3 ? 3 : (comps_per_vertex > MAX_COMP ? MAX_COMP
                                                                      : comps_per_vertex);
      if (comp_idx < 3 && vert_idx < 3) coords[vert_idx * 3 + comp_idx] = v;
      if (comp_idx + 1 < cnt) begin
        comp_idx++;
        return;
      end
      comp_idx = 0;
      if (vert_idx < 2) begin
        vert_idx++;
        return;
      end
      vert_idx = 0;
      compute_normal();
    endfunction

    function void check_normal(normal_t got);
      normal_t exp_n;
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected result item %p", $time, got);
        errors++;
        return;
      end
      exp_n = expected_normals.pop_front();
      if (got.nx !== exp_n.nx)
        $display("%0t: normal_x expected %0d got %0d", $time, exp_n.nx, got.nx);
      if (got.ny !== exp_n.ny)
        $display("%0t: normal_y expected %0d got %0d", $time, exp_n.ny, got.ny);
      if (got.nz !== exp_n.nz)
        $display("%0t: normal_z expected %0d got %0d", $time, exp_n.nz, got.nz);
      if (got.degen !== exp_n.degen)
        $display("%0t: degenerate expected %0b got %0b", $time, exp_n.degen, got.degen);
      if (got.last !== exp_n.last)
        $display("%0t: last expected %0b got %0b", $time, exp_n.last, got.last);
      if (got !== exp_n) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] in_component_value = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate, out_last;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [3:0] cfg_data = 0;

  normal_board board = new();
  int send_idle = 24;
  int recv_idle = 51;
  int hold_off = 0;
  int cycles = 0;
  int sent = 0;

  triangle_face_normal #(.MAX_COMPONENTS(MAX_COMP)) i_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_component_value,
    .out_valid, .out_ready, .out_normal_x, .out_normal_y, .out_normal_z,
    .out_degenerate, .out_last,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_normal('{out_normal_x, out_normal_y, out_normal_z,
                           out_degenerate, out_last});
  end

  task automatic send_item(logic signed [31:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_component_value <= v;
    do @(posedge clk); while (!in_ready);
    board.note_component(v);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.expected_normals.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic [3:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    board.comps_per_vertex = d;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord(int shape);
    case (shape)
      0: return $urandom;
      1: return $signed($urandom_range(2000)) - 1000;
      2: return $signed($urandom_range(1 << 20)) - (1 << 19);
      default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  // one triangle at the current count; kind picks content
  task automatic send_triangle(int kind, int cnt);
    logic signed [31:0] v[9];
    int shape;
    shape = $urandom_range(3);
    for (int i = 0; i < 9; i++) v[i] = rand_coord(shape);
    if (kind == 1) for (int i = 3; i < 9; i++) v[i] = v[i % 3];
    if (kind == 2) for (int i = 0; i < 3; i++) v[6 + i] = 2 * v[3 + i] - v[i];
    if (kind == 3) begin
      v[3] = v[0]; v[6] = v[0];
    end
    for (int vx = 0; vx < 3; vx++)
      for (int c = 0; c < cnt; c++)
        send_item(c < 3 ? v[vx * 3 + c] : $urandom);
  endtask

  initial begin
    logic [3:0] cfg_seq[8];
    int eff;
    cfg_seq = '{4'd3, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd9, 4'd6};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, degenerate, axis planes
    send_item(32'sh80000000); send_item(32'sh80000000); send_item(32'sh80000000);
    send_item(32'sh7fffffff); send_item(32'sh80000000); send_item(32'sh80000000);
    send_item(32'sh80000000); send_item(32'sh7fffffff); send_item(32'sh80000000);
    send_item(0); send_item(0); send_item(0);
    send_item(32'sh10000); send_item(0); send_item(0);
    send_item(0); send_item(32'sh10000); send_item(0);
    for (int i = 0; i < 9; i++) send_item(32'sh12345);
    drain();

    // count change mid-vertex keeps the counters
    write_cfg(4'd5);
    for (int i = 0; i < 4; i++) send_item($urandom);
    drain();
    write_cfg(4'd3);
    for (int i = 0; i < 5; i++) send_item($urandom);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin send_idle = 24; recv_idle = 51; end
      else if (ph < 6) begin send_idle = 51; recv_idle = 24; end
      else begin send_idle = 0; recv_idle = 0; end
      write_cfg(cfg_seq[ph]);
      eff = cfg_seq[ph] < 3 ? 3 : (cfg_seq[ph] > MAX_COMP ? MAX_COMP : cfg_seq[ph]);
      if (ph == 1) hold_off = 6000;
      for (int n = 0; n < 40; n += 3 * eff) begin
        int r;
        r = $urandom_range(9);
        send_triangle(r < 6 ? 0 : r - 6, eff);
      end
      drain();
    end

    if (board.errors == 0 && board.expected_normals.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
